>>> sv/rmr_pkg.sv
package rmr_pkg;

    localparam int unsigned OPERAND_WIDTH_DEF = 32;
    localparam int unsigned IN_W              = 32;
    localparam int unsigned RES_W             = 64;
    localparam int unsigned S_TDATA_W         = 4 * IN_W;
    localparam int unsigned M_TDATA_W         = 2 * RES_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_N,
        ST_MUL_D,
        ST_GCD,
        ST_GFIX,
        ST_DIV_N,
        ST_DIV_D,
        ST_DONE
    } rmr_state_t;

    typedef struct packed {
        logic [IN_W-1:0] b_den;
        logic [IN_W-1:0] b_num;
        logic [IN_W-1:0] a_den;
        logic [IN_W-1:0] a_num;
    } rmr_in_t;

    typedef struct packed {
        logic             err;
        logic             neg_num;
        logic             neg_den;
        logic [RES_W-1:0] mag_num;
        logic [RES_W-1:0] mag_den;
    } rmr_res_t;

    // handshake between the stream shell and the engine
    typedef struct packed {
        logic idle;
        logic done;
    } rmr_stat_t;

endpackage

>>> sv/rmr_engine.sv
module rmr_engine #(
    parameter int unsigned OPERAND_WIDTH = rmr_pkg::OPERAND_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  rmr_pkg::rmr_in_t  in_word,
    input  logic              ack,
    output rmr_pkg::rmr_stat_t stat,
    output rmr_pkg::rmr_res_t res
);
    import rmr_pkg::*;

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned PW = 2 * W;
    localparam int unsigned SW = PW + 1;
    localparam int unsigned CW = $clog2(PW);

    rmr_state_t state_reg, state_next;

    logic [W-1:0]  mag_reg [4];
    logic [W-1:0]  mag_next [4];
    logic          neg_num_reg, neg_num_next;
    logic          neg_den_reg, neg_den_next;
    logic          err_reg, err_next;
    logic [PW-1:0] pn_reg, pn_next;
    logic [PW-1:0] pd_reg, pd_next;
    logic [PW-1:0] u_reg, u_next;
    logic [PW-1:0] v_reg, v_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // input split into sign and magnitude
    logic [W-1:0]  in_raw [4];
    logic [W-1:0]  in_mag [4];
    logic          in_neg [4];

    // shared multiplier and subtractor
    logic [W-1:0]  mul_a, mul_b;
    logic [PW-1:0] prod;
    logic [SW-1:0] sub_a, sub_b;
    logic [SW:0]   diff;
    logic          borrow;
    logic [PW-1:0] dq;

    assign in_raw[0] = in_word.a_num[W-1:0];
    assign in_raw[1] = in_word.a_den[W-1:0];
    assign in_raw[2] = in_word.b_num[W-1:0];
    assign in_raw[3] = in_word.b_den[W-1:0];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_neg[i] = in_raw[i][W-1];
            in_mag[i] = in_neg[i] ? (~in_raw[i] + 1'b1) : in_raw[i];
        end
    end

    // numerator pair in MUL_N, denominator pair otherwise
    assign mul_a = (state_reg == ST_MUL_N) ? mag_reg[0] : mag_reg[1];
    assign mul_b = (state_reg == ST_MUL_N) ? mag_reg[2] : mag_reg[3];
    assign prod  = mul_a * mul_b;

    // dividend being worked on in place
    assign dq = (state_reg == ST_DIV_N) ? pn_reg : pd_reg;

    always_comb begin
        if (state_reg == ST_GCD) begin
            sub_a = {1'b0, u_reg};
            sub_b = {1'b0, v_reg};
        end else begin
            sub_a = {rem_reg, dq[PW-1]};
            sub_b = {1'b0, u_reg};
        end
    end

    assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = diff[SW];

    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        neg_num_next = neg_num_reg;
        neg_den_next = neg_den_reg;
        err_next     = err_reg;
        pn_next      = pn_reg;
        pd_next      = pd_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        rem_next     = rem_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    mag_next     = in_mag;
                    neg_num_next = in_neg[0] ^ in_neg[2];
                    neg_den_next = in_neg[1] ^ in_neg[3];
                    err_next     = (in_raw[1] == '0) || (in_raw[3] == '0);
                    state_next   = ((in_raw[1] == '0) || (in_raw[3] == '0)) ? ST_DONE
                                                                             : ST_MUL_N;
                end
            end
            ST_MUL_N: begin
                pn_next    = prod;
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                pd_next    = prod;
                u_next     = pn_reg;
                v_next     = prod;
                k_next     = '0;
                state_next = ST_GCD;
            end
            ST_GCD: begin
                // binary gcd; v never reaches zero, u does when the two meet
                if (u_reg == '0) begin
                    u_next     = v_reg;
                    state_next = ST_GFIX;
                end else if (!u_reg[0] && !v_reg[0]) begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end else if (!u_reg[0]) begin
                    u_next = u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_next = v_reg >> 1;
                end else if (borrow) begin
                    u_next = v_reg;
                    v_next = u_reg;
                end else begin
                    u_next = diff[PW-1:0];
                end
            end
            ST_GFIX: begin
                // restore the common power of two
                if (k_reg == '0) begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV_N;
                end else begin
                    u_next = u_reg << 1;
                    k_next = k_reg - 1'b1;
                end
            end
            ST_DIV_N, ST_DIV_D: begin
                // restoring division, one quotient bit a cycle
                rem_next = borrow ? sub_a[PW-1:0] : diff[PW-1:0];
                if (state_reg == ST_DIV_N) begin
                    pn_next = {pn_reg[PW-2:0], ~borrow};
                end else begin
                    pd_next = {pd_reg[PW-2:0], ~borrow};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(PW - 1)) begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = (state_reg == ST_DIV_N) ? ST_DIV_D : ST_DONE;
                end
            end
            ST_DONE: begin
                if (ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        neg_num_reg <= neg_num_next;
        neg_den_reg <= neg_den_next;
        err_reg     <= err_next;
        pn_reg      <= pn_next;
        pd_reg      <= pd_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        rem_reg     <= rem_next;
        k_reg       <= k_next;
        cnt_reg     <= cnt_next;
    end

    assign stat.idle   = (state_reg == ST_IDLE);
    assign stat.done   = (state_reg == ST_DONE);
    assign res.err     = err_reg;
    assign res.neg_num = neg_num_reg;
    assign res.neg_den = neg_den_reg;
    assign res.mag_num = RES_W'(pn_reg);
    assign res.mag_den = RES_W'(pd_reg);

endmodule

>>> sv/rational_multiply_reduce.sv
// Multiplies two signed fractions a_num/a_den * b_num/b_den and returns the
// product reduced by the positive gcd of its numerator and denominator. Signs
// stay where the products put them, so res_den may be negative; a zero
// numerator gives 0 over +1 or -1. If either denominator is zero the result
// word carries zero_den_error = 1 (m_tuser) with both fields zero. Only the low
// OPERAND_WIDTH bits of each input field are used, sign extended from the top
// one. One word is worked on at a time: s_tready is high only while the engine
// is idle. An item goes through two multiplies (numerator, then denominator
// product), a binary gcd loop (shift, swap or subtract each cycle, plus the
// restore of the common power of two), then two restoring divisions of the
// numerator and the denominator by the gcd, all through one shared subtractor.
// A zero denominator skips straight to the done state. A finished result sits
// in an output register, so the engine is released as soon as that register
// can take it.
module rational_multiply_reduce #(
    parameter int unsigned OPERAND_WIDTH = rmr_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // a_num, a_den, b_num, b_den
    input  logic [rmr_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // res_num, res_den
    output logic [rmr_pkg::M_TDATA_W-1:0]   m_tdata,
    // zero_den_error
    output logic [0:0]                      m_tuser
);
    import rmr_pkg::*;

    rmr_in_t   in_word;
    rmr_res_t  res;
    rmr_stat_t stat;
    logic      start;
    logic      ack;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    logic [RES_W-1:0] num_out, den_out;

    assign in_word  = rmr_in_t'(s_tdata);
    assign s_tready = stat.idle;
    assign start    = s_tvalid && stat.idle;

    rmr_engine #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .in_word (in_word),
        .ack     (ack),
        .stat    (stat),
        .res     (res)
    );

    // output register takes the result once the previous word is gone
    assign ack = stat.done && (!m_tvalid_reg || m_tready);

    // sign applied at full result width; error words read as zero
    always_comb begin
        if (res.err) begin
            num_out = '0;
            den_out = '0;
        end else begin
            num_out = res.neg_num ? (~res.mag_num + 1'b1) : res.mag_num;
            den_out = res.neg_den ? (~res.mag_den + 1'b1) : res.mag_den;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (ack) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {den_out, num_out};
            m_tuser_next  = res.err;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
